// File: rtl/cde_pkg.sv
package cde_pkg;

   localparam int MAX_CLASSES = 256;
   localparam int KEY_BITS    = 32;

   localparam int ROW_W     = 16;
   localparam int IN_KEY_W  = 32;
   localparam int CLASS_W   = $clog2(MAX_CLASSES);
   localparam int USED_W    = $clog2(MAX_CLASSES + 1);
   localparam int CLASS_ID_W = 8;
   localparam int COUNT_W   = 16;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int USER_NEW_BIT  = 0;
   localparam int USER_FULL_BIT = 1;

   typedef struct packed {
      logic start;
      logic scan;
      logic count_write;
      logic new_write;
      logic full_load;
   } cde_cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_end;
      logic full;
   } cde_stat_type;

endpackage

// File: rtl/cde_ctrl.sv
module cde_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  cde_pkg::cde_stat_type stat,
   output cde_pkg::cde_cmd_type  cmd
);
   import cde_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COUNT,
      ST_INSERT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               state_in = ST_COUNT;
            end else if (stat.scan_end) begin
               state_in = ST_INSERT;
            end
         end
         ST_COUNT: begin
            if (out_free) begin
               cmd.count_write = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_INSERT: begin
            if (out_free) begin
               cmd.full_load = stat.full;
               cmd.new_write = !stat.full;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign load = cmd.count_write || cmd.new_write || cmd.full_load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/cde_datapath.sv
module cde_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cde_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  cde_pkg::cde_cmd_type              cmd,
   output cde_pkg::cde_stat_type             stat,
   output logic [cde_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [cde_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import cde_pkg::*;

   logic [KEY_BITS-1:0] key_mem [MAX_CLASSES];
   logic [COUNT_W-1:0]  cnt_mem [MAX_CLASSES];

   logic [ROW_W-1:0]    row_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [USED_W-1:0]   addr_ff;
   logic                cmp_valid_ff;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [CLASS_W-1:0]  cmp_idx_ff;
   logic [CLASS_W-1:0]  pos_ff;
   logic [COUNT_W-1:0]  cnt_rd_ff;

   logic [ROW_W-1:0]      out_row_ff;
   logic [CLASS_ID_W-1:0] out_class_ff;
   logic                  out_new_ff;
   logic [COUNT_W-1:0]    out_count_ff;
   logic                  out_full_ff;

   logic [63:0]         key_ext;
   logic                issue;
   logic                match;
   logic [COUNT_W-1:0]  cnt_next;
   logic [15:0]         pos_wide;
   logic [15:0]         used_wide;

   // sign extend the 32-bit key, keep the low key bits
   assign key_ext = {{32{req_tdata[ROW_W+IN_KEY_W-1]}}, req_tdata[ROW_W +: IN_KEY_W]};

   assign issue = cmd.scan && (addr_ff < used_ff);
   assign match = cmp_valid_ff && (key_rd_ff == key_ff);

   assign stat.hit      = match;
   assign stat.scan_end = (addr_ff == used_ff) && !match;
   assign stat.full     = (used_ff == USED_W'(MAX_CLASSES));

   assign cnt_next  = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + COUNT_W'(1);
   assign pos_wide  = 16'(pos_ff);
   assign used_wide = 16'(used_ff);

   always_comb begin
      used_in = used_ff;
      if (cmd.new_write) begin
         used_in = used_ff + USED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         addr_ff      <= '0;
      end else begin
         used_ff <= used_in;
         if (cmd.start) begin
            addr_ff      <= '0;
            cmp_valid_ff <= 1'b0;
         end else if (cmd.scan) begin
            cmp_valid_ff <= issue;
            if (issue) begin
               addr_ff <= addr_ff + USED_W'(1);
            end
         end
      end
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.new_write) begin
         key_mem[used_ff[CLASS_W-1:0]] <= key_ff;
      end
      if (issue) begin
         key_rd_ff  <= key_mem[addr_ff[CLASS_W-1:0]];
         cmp_idx_ff <= addr_ff[CLASS_W-1:0];
      end
   end

   // count memory
   always_ff @(posedge clock) begin
      if (cmd.new_write) begin
         cnt_mem[used_ff[CLASS_W-1:0]] <= COUNT_W'(1);
      end else if (cmd.count_write) begin
         cnt_mem[pos_ff] <= cnt_next;
      end
      if (cmd.scan && match) begin
         cnt_rd_ff <= cnt_mem[cmp_idx_ff];
         pos_ff    <= cmp_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff <= req_tdata[ROW_W-1:0];
         key_ff <= key_ext[KEY_BITS-1:0];
      end
      if (cmd.count_write) begin
         out_row_ff   <= row_ff;
         out_class_ff <= pos_wide[CLASS_ID_W-1:0];
         out_new_ff   <= 1'b0;
         out_count_ff <= cnt_next;
         out_full_ff  <= 1'b0;
      end else if (cmd.new_write) begin
         out_row_ff   <= row_ff;
         out_class_ff <= used_wide[CLASS_ID_W-1:0];
         out_new_ff   <= 1'b1;
         out_count_ff <= COUNT_W'(1);
         out_full_ff  <= 1'b0;
      end else if (cmd.full_load) begin
         out_row_ff   <= row_ff;
         out_class_ff <= '0;
         out_new_ff   <= 1'b0;
         out_count_ff <= '0;
         out_full_ff  <= 1'b1;
      end
   end

   assign rsp_tdata = {out_count_ff, out_class_ff, out_row_ff};
   assign rsp_tuser = {out_full_ff, out_new_ff};

endmodule

// File: rtl/category_dictionary_encoder_core.sv
// Dictionary encoder: each request carries a row number and a 32-bit signed key; the
// response echoes the row and gives the key's dense class number, a new-class flag,
// the saturating occurrence count after this request and a table-full flag. Keys are
// matched by walking the key memory one entry per cycle through its single registered
// read port; a request is accepted while idle, scanned, and its response is loaded into
// the output register once that register is free (a hit updates the count, a miss
// inserts the key or reports a full table). One request is in flight at a time; the next
// is accepted once the previous response has been loaded into the output register. After
// reset the table is empty and no clearing pass is needed.
module category_dictionary_encoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cde_pkg::REQ_DATA_W-1:0]    req_tdata,  // row_index, key_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cde_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // row_out, class_id, class_count
   output logic [cde_pkg::RSP_USER_W-1:0]    rsp_tuser   // is_new_class, table_full
);
   import cde_pkg::*;

   cde_cmd_type  cmd;
   cde_stat_type stat;

   cde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cde_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// File: rtl/cde_checker.sv
module cde_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cde_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [cde_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import cde_pkg::*;

   logic                is_new;
   logic                is_full;
   logic [COUNT_W-1:0]  count;
   logic [CLASS_ID_W-1:0] class_id;

   assign is_new   = rsp_tuser[USER_NEW_BIT];
   assign is_full  = rsp_tuser[USER_FULL_BIT];
   assign class_id = rsp_tdata[ROW_W +: CLASS_ID_W];
   assign count    = rsp_tdata[ROW_W+CLASS_ID_W +: COUNT_W];

   // stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // full table response carries no class
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && is_full |-> !is_new && class_id == '0 && count == '0)
      else $error("table full response not cleared");

   // a new class starts with a count of one, a stored class never reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !is_full |-> count != '0 && (!is_new || count == COUNT_W'(1)))
      else $error("bad class count");

   // an accepted request moves the control into its scan, so no second request is accepted back to back
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

endmodule

bind category_dictionary_encoder_core cde_checker u_cde_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
